// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int PRIO_W = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int STAT_W = 2;

   // request tdata: item_data, item_priority
   localparam int REQ_BITS   = DATA_W + PRIO_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response tdata: popped_data, head_data, tail_data, entry_count, status
   localparam int RSP_POP_LO  = 0;
   localparam int RSP_HEAD_LO = DATA_W;
   localparam int RSP_TAIL_LO = 2 * DATA_W;
   localparam int RSP_CNT_LO  = 3 * DATA_W;
   localparam int RSP_STAT_LO = 3 * DATA_W + CNT_W;
   localparam int RSP_BITS    = 3 * DATA_W + CNT_W + STAT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic report;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: joins controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   channel | direction | ports                        | payload
//   req     | in        | req_tvalid/tready/tdata/tuser| tuser: mode; tdata: item_data,
//           |           |                              |   item_priority
//   rsp     | out       | rsp_tvalid/tready/tdata      | tdata: popped_data, head_data,
//           |           |                              |   tail_data, entry_count, status
//
// Each transaction runs capture, an update of all entry cells in parallel
// (insert or shift toward the head), then load of the result register.
// The result register holds a finished result while the next transaction is taken.
// A stalled result register holds the controller in its report step.
// Synchronous reset empties the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [31:0] item_data, [47:32] item_priority
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input  wire logic [0:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] popped_data, [63:32] head_data, [95:64] tail_data,
   // [100:96] entry_count, [102:101] status, [103] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   spq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; drives commands to spq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type dp_status,
   output ctl_cmd_type        cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            // hold until the output slot can take the result
            if (dp_status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.report  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_REPORT: begin
            cmd.report = dp_status.slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
// Datapath of the sorted priority queue: sorted entry cells, count and result register.
// Depends on spq_pkg; sequenced by spq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_cmd_type             cmd,
   output dp_status_type                dp_status,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [0:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata
);

   // captured transaction
   logic              mode_ff;
   logic [DATA_W-1:0] item_data_ff;
   logic [PRIO_W-1:0] item_prio_ff;

   // sorted cells, highest priority at index 0
   logic [DATA_W-1:0] data_ff [DEPTH];
   logic [DATA_W-1:0] data_in [DEPTH];
   logic [PRIO_W-1:0] prio_ff [DEPTH];
   logic [PRIO_W-1:0] prio_in [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic [DATA_W-1:0] popped_ff;
   logic [DATA_W-1:0] popped_in;
   logic [STAT_W-1:0] status_ff;
   logic [STAT_W-1:0] status_in;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   logic [DEPTH-1:0] keep;
   logic             is_full;
   logic             is_empty;
   logic [CNT_W-1:0] tail_pos;
   logic [IDX_W-1:0] tail_idx;
   logic [DATA_W-1:0] head_val;
   logic [DATA_W-1:0] tail_val;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_tuser[0];
         item_data_ff <= req_tdata[DATA_W-1:0];
         item_prio_ff <= req_tdata[DATA_W +: PRIO_W];
      end
   end

   // an entry stays in place when it is stored and ranks at or above the new item
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) &&
                   ($signed(prio_ff[i]) >= $signed(item_prio_ff));
      end
   end

   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      status_in = STATUS_OK;
      for (int i = 0; i < DEPTH; i++) begin
         data_in[i] = data_ff[i];
         prio_in[i] = prio_ff[i];
      end
      if (mode_ff == MODE_PUSH) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
               if (!keep[i]) begin
                  if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                     data_in[i] = item_data_ff;
                     prio_in[i] = item_prio_ff;
                  end else begin
                     data_in[i] = data_ff[(i == 0) ? 0 : i - 1];
                     prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
                  end
               end
            end
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            count_in  = count_ff - 1'b1;
            popped_in = data_ff[0];
            // advance every entry one place toward the head
            for (int i = 0; i < DEPTH - 1; i++) begin
               data_in[i] = data_ff[i + 1];
               prio_in[i] = prio_ff[i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            data_ff[i] <= data_in[i];
            prio_ff[i] <= prio_in[i];
         end
         popped_ff <= popped_in;
         status_ff <= status_in;
      end
   end

   assign tail_pos = count_ff - 1'b1;
   assign tail_idx = tail_pos[IDX_W-1:0];
   assign head_val = is_empty ? '0 : data_ff[0];
   assign tail_val = is_empty ? '0 : data_ff[tail_idx];

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_POP_LO  +: DATA_W] = popped_ff;
      rsp_data_in[RSP_HEAD_LO +: DATA_W] = head_val;
      rsp_data_in[RSP_TAIL_LO +: DATA_W] = tail_val;
      rsp_data_in[RSP_CNT_LO  +: CNT_W]  = count_ff;
      rsp_data_in[RSP_STAT_LO +: STAT_W] = status_ff;
   end

   assign dp_status.slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.report) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
`timescale 1ns / 1ps
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [CNT_W-1:0]  rsp_count;
   logic [STAT_W-1:0] rsp_status;

   assign rsp_count  = rsp_tdata[RSP_CNT_LO +: CNT_W];
   assign rsp_status = rsp_tdata[RSP_STAT_LO +: STAT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new transaction taken while one is in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= CNT_W'(DEPTH))
      else $error("entry count beyond capacity");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STATUS_EMPTY |->
         rsp_count == '0 && rsp_tdata[RSP_POP_LO +: DATA_W] == '0 &&
         rsp_tdata[RSP_HEAD_LO +: DATA_W] == '0)
      else $error("empty error with entries or data shown");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STATUS_FULL |->
         rsp_count == CNT_W'(DEPTH) && rsp_tdata[RSP_POP_LO +: DATA_W] == '0)
      else $error("full error with queue not full");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
